>>> hdl/lift_pd_controller_with_ramp_macros.svh
// Assertion macros for the lift controller.
`ifndef LIFT_PD_CONTROLLER_WITH_RAMP_MACROS_SVH
`define LIFT_PD_CONTROLLER_WITH_RAMP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define LPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/lpd_pkg.sv
package lpd_pkg;

    localparam int DATA_W = 32;
    localparam int GAIN_W = 31;
    localparam int MUL_A_W = DATA_W + 1;
    localparam int MUL_B_W = DATA_W;
    localparam int PROD_W = MUL_A_W + MUL_B_W;
    localparam int WIDE_W = PROD_W + 1;
    localparam int CFG_ADDR_W = 3;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_LIFT  = 2'd1;
    localparam logic [1:0] OP_LOWER = 2'd2;
    localparam logic [1:0] OP_START = 2'd3;

    localparam logic [1:0] MODE_DISABLED = 2'd0;
    localparam logic [1:0] MODE_RAISING  = 2'd1;
    localparam logic [1:0] MODE_LOWERING = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_MAX_HEIGHT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_HEIGHT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_UP_STEP    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DOWN_STEP  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_INV_TICK   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_P_GAIN     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_D_GAIN     = 3'd6;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    // Clamp a 34-bit signed value to 32 bits.
    function automatic logic signed [DATA_W-1:0] lpd_sat34(input logic signed [DATA_W+1:0] v);
        logic all_one;
        logic all_zero;
        all_one  = &v[DATA_W+1:DATA_W-1];
        all_zero = ~|v[DATA_W+1:DATA_W-1];
        if (all_one || all_zero) begin
            return v[DATA_W-1:0];
        end
        return v[DATA_W+1] ? SAT_MIN : SAT_MAX;
    endfunction

    // Floor-rescale a wide Q32.32 product by 2^16, then clamp to 32 bits.
    function automatic logic signed [DATA_W-1:0] lpd_sat_q16(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] s;
        logic all_one;
        logic all_zero;
        s        = v >>> 16;
        all_one  = &s[WIDE_W-1:DATA_W-1];
        all_zero = ~|s[WIDE_W-1:DATA_W-1];
        if (all_one || all_zero) begin
            return s[DATA_W-1:0];
        end
        return s[WIDE_W-1] ? SAT_MIN : SAT_MAX;
    endfunction

endpackage

>>> hdl/lpd_mul.sv
module lpd_mul (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [lpd_pkg::MUL_A_W-1:0]   i_a,
    input  logic signed [lpd_pkg::MUL_B_W-1:0]   i_b,
    output logic signed [lpd_pkg::PROD_W-1:0]    o_prod
);
    import lpd_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;

    assign n_prod = PROD_W'(i_a) * PROD_W'(i_b);
    assign o_prod = r_prod;

    // Hold the product when idle so the post stage can read it again.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

endmodule

>>> hdl/lift_pd_controller_with_ramp.sv
// Lift controller with a ramped height set point and PD force output.
// Input channel: i_valid / o_ready carries one request (opcode and the
// measured x, y, z). Output channel: o_valid / i_ready carries one result
// (three saturated forces, apply flag and the mode after the request).
// Configuration: i_cfg_we writes i_cfg_wdata to the register at i_cfg_addr
// in the same edge; write only while no request is in flight.
// Sequence: a tick in raising or lowering mode runs from accept through
// one ramp step, seven passes through the single shared 33x32
// multiplier, one sum step and one output load. Commands, start and
// disabled ticks go from the ramp step straight to the output load.
// One request is in work at a time.
// The output register lets a new request be accepted while the last result
// waits; a finished request holds in its last cycle while the receiver
// stalls and an older result is still unread.
// Reset (synchronous, i_rst_n low) restores the register defaults, puts
// the controller in raising mode with target and history at zero, and
// drops o_valid.
module lift_pd_controller_with_ramp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [lpd_pkg::CFG_ADDR_W-1:0]         i_cfg_addr,
    input  logic [lpd_pkg::DATA_W-1:0]             i_cfg_wdata,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [1:0]                             i_opcode,
    input  logic signed [lpd_pkg::DATA_W-1:0]      i_pos_x,
    input  logic signed [lpd_pkg::DATA_W-1:0]      i_pos_y,
    input  logic signed [lpd_pkg::DATA_W-1:0]      i_pos_z,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [lpd_pkg::DATA_W-1:0]      o_force_x,
    output logic signed [lpd_pkg::DATA_W-1:0]      o_force_y,
    output logic signed [lpd_pkg::DATA_W-1:0]      o_force_z,
    output logic                                   o_apply_force,
    output logic [1:0]                             o_mode
);
    import lpd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RAMP, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_SUM, S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic signed [DATA_W-1:0] r_max_height;
    logic signed [DATA_W-1:0] r_min_height;
    logic [GAIN_W-1:0]        r_up_step;
    logic [GAIN_W-1:0]        r_down_step;
    logic [GAIN_W-1:0]        r_inv_tick;
    logic [GAIN_W-1:0]        r_p_gain;
    logic [GAIN_W-1:0]        r_d_gain;

    // controller state
    logic [1:0]               r_mode;
    logic signed [DATA_W-1:0] r_target;
    logic signed [DATA_W-1:0] r_prev_error;
    logic signed [DATA_W-1:0] r_prev_x;
    logic signed [DATA_W-1:0] r_prev_y;
    logic signed [DATA_W-1:0] r_prev_z;

    // working registers
    logic [1:0]               r_op;
    logic signed [DATA_W-1:0] r_px;
    logic signed [DATA_W-1:0] r_py;
    logic signed [DATA_W-1:0] r_pz;
    logic                     r_active;
    logic signed [DATA_W-1:0] r_err;
    logic signed [DATA_W-1:0] r_derr;
    logic signed [DATA_W-1:0] r_vx;
    logic signed [DATA_W-1:0] r_vy;
    logic signed [DATA_W-1:0] r_fx;
    logic signed [DATA_W-1:0] r_fy;
    logic signed [DATA_W-1:0] r_fz;
    logic signed [PROD_W-1:0] r_acc;

    // output register
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_fx;
    logic signed [DATA_W-1:0] r_out_fy;
    logic signed [DATA_W-1:0] r_out_fz;
    logic                     r_out_apply;
    logic [1:0]               r_out_mode;

    // ramp and error
    logic signed [DATA_W+1:0] ramp_up;
    logic signed [DATA_W+1:0] ramp_dn;
    logic signed [DATA_W+1:0] err_wide;
    logic [1:0]               n_mode;
    logic signed [DATA_W-1:0] n_target;
    logic signed [DATA_W-1:0] n_err;
    logic                     n_active;

    // shared multiplier and post stage
    logic                      mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [WIDE_W-1:0]  post_in;
    logic signed [DATA_W-1:0]  post_out;

    logic out_free;

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_force_x     = r_out_fx;
    assign o_force_y     = r_out_fy;
    assign o_force_z     = r_out_fz;
    assign o_apply_force = r_out_apply;
    assign o_mode        = r_out_mode;
    assign out_free      = !r_out_valid || i_ready;

    always_comb begin
        ramp_up  = (DATA_W+2)'(r_target) + (DATA_W+2)'({1'b0, r_up_step});
        ramp_dn  = (DATA_W+2)'(r_target) - (DATA_W+2)'({1'b0, r_down_step});
        n_mode   = r_mode;
        n_target = r_target;
        n_active = 1'b0;
        case (r_op)
            OP_TICK: begin
                case (r_mode)
                    MODE_RAISING: begin
                        n_active = 1'b1;
                        if (ramp_up > (DATA_W+2)'(r_max_height)) begin
                            n_target = r_max_height;
                        end else begin
                            n_target = lpd_sat34(ramp_up);
                        end
                    end
                    MODE_LOWERING: begin
                        n_active = 1'b1;
                        if (ramp_dn < (DATA_W+2)'(r_min_height)) begin
                            n_mode = MODE_DISABLED;
                        end
                        n_target = lpd_sat34(ramp_dn);
                    end
                    default: begin
                        n_active = 1'b0;
                    end
                endcase
            end
            OP_LIFT: begin
                if (r_mode == MODE_LOWERING) begin
                    n_mode = MODE_RAISING;
                end else if (r_mode != MODE_RAISING) begin
                    n_mode   = MODE_RAISING;
                    n_target = r_prev_z;
                end
            end
            OP_LOWER: begin
                if (r_mode == MODE_RAISING) begin
                    n_mode = MODE_LOWERING;
                end
            end
            default: begin
                n_mode   = MODE_RAISING;
                n_target = r_pz;
            end
        endcase
        err_wide = (DATA_W+2)'(n_target) - (DATA_W+2)'(r_pz);
        n_err    = lpd_sat34(err_wide);
    end

    // Operand select for the shared multiplier.
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (r_state)
            S_M1: begin
                mul_a = MUL_A_W'(r_err) - MUL_A_W'(r_prev_error);
                mul_b = MUL_B_W'({1'b0, r_inv_tick});
            end
            S_M2: begin
                mul_a = MUL_A_W'(r_px) - MUL_A_W'(r_prev_x);
                mul_b = MUL_B_W'({1'b0, r_inv_tick});
            end
            S_M3: begin
                mul_a = MUL_A_W'(r_py) - MUL_A_W'(r_prev_y);
                mul_b = MUL_B_W'({1'b0, r_inv_tick});
            end
            S_M4: begin
                mul_a = MUL_A_W'(r_vx);
                mul_b = MUL_B_W'({1'b0, r_d_gain});
            end
            S_M5: begin
                mul_a = MUL_A_W'(r_vy);
                mul_b = MUL_B_W'({1'b0, r_d_gain});
            end
            S_M6: begin
                mul_a = MUL_A_W'(r_err);
                mul_b = MUL_B_W'({1'b0, r_p_gain});
            end
            S_M7: begin
                mul_a = MUL_A_W'(r_derr);
                mul_b = MUL_B_W'({1'b0, r_d_gain});
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    lpd_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Post stage: lateral damping negates, the z force adds both products.
    always_comb begin
        case (r_state)
            S_M5, S_M6: post_in = WIDE_W'(0) - WIDE_W'(prod);
            S_SUM:      post_in = WIDE_W'(r_acc) + WIDE_W'(prod);
            default:    post_in = WIDE_W'(prod);
        endcase
        post_out = lpd_sat_q16(post_in);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_max_height <= 32'sd65536;
            r_min_height <= '0;
            r_up_step    <= GAIN_W'(65);
            r_down_step  <= GAIN_W'(65);
            r_inv_tick   <= GAIN_W'(65536000);
            r_p_gain     <= '0;
            r_d_gain     <= '0;
            r_mode       <= MODE_RAISING;
            r_target     <= '0;
            r_prev_error <= '0;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_prev_z     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_MAX_HEIGHT: r_max_height <= i_cfg_wdata;
                    REG_MIN_HEIGHT: r_min_height <= i_cfg_wdata;
                    REG_UP_STEP:    r_up_step    <= i_cfg_wdata[GAIN_W-1:0];
                    REG_DOWN_STEP:  r_down_step  <= i_cfg_wdata[GAIN_W-1:0];
                    REG_INV_TICK:   r_inv_tick   <= i_cfg_wdata[GAIN_W-1:0];
                    REG_P_GAIN:     r_p_gain     <= i_cfg_wdata[GAIN_W-1:0];
                    REG_D_GAIN:     r_d_gain     <= i_cfg_wdata[GAIN_W-1:0];
                    default: begin
                        // drop writes to unused indexes
                    end
                endcase
            end

            // S_DONE refills the slot itself when it is freed
            if (r_out_valid && i_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op    <= i_opcode;
                        r_px    <= i_pos_x;
                        r_py    <= i_pos_y;
                        r_pz    <= i_pos_z;
                        r_state <= S_RAMP;
                    end
                end
                S_RAMP: begin
                    r_mode   <= n_mode;
                    r_target <= n_target;
                    r_err    <= n_err;
                    r_active <= n_active;
                    r_fx     <= '0;
                    r_fy     <= '0;
                    r_fz     <= '0;
                    r_state  <= n_active ? S_M1 : S_DONE;
                end
                S_M1: r_state <= S_M2;
                S_M2: begin
                    r_derr  <= post_out;
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_vx    <= post_out;
                    r_state <= S_M4;
                end
                S_M4: begin
                    r_vy    <= post_out;
                    r_state <= S_M5;
                end
                S_M5: begin
                    r_fx    <= post_out;
                    r_state <= S_M6;
                end
                S_M6: begin
                    r_fy    <= post_out;
                    r_state <= S_M7;
                end
                S_M7: begin
                    r_acc   <= prod;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_fz    <= post_out;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_fx    <= r_fx;
                        r_out_fy    <= r_fy;
                        r_out_fz    <= r_fz;
                        r_out_apply <= r_active && !r_fz[DATA_W-1] && (r_fz != '0);
                        r_out_mode  <= r_mode;
                        if (r_op == OP_TICK || r_op == OP_START) begin
                            r_prev_x     <= r_px;
                            r_prev_y     <= r_py;
                            r_prev_z     <= r_pz;
                            r_prev_error <= r_active ? r_err : '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`include "lift_pd_controller_with_ramp_macros.svh"

    `LPD_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "request accepted but still ready")
    `LPD_ASSERT_NOW(a_apply_needs_push, i_clk, i_rst_n, o_valid && o_apply_force, !o_force_z[DATA_W-1] && (o_force_z != '0), "apply flag without positive z force")
    `LPD_ASSERT_NOW(a_mode_code, i_clk, i_rst_n, o_valid, (o_mode == MODE_DISABLED) || (o_mode == MODE_RAISING) || (o_mode == MODE_LOWERING), "result mode code out of range")
    `LPD_ASSERT_NOW(a_done_when_free, i_clk, i_rst_n, (r_state == S_DONE) && !o_valid, $past(r_state) != S_IDLE, "result stage entered without a request")

endmodule

>>> bench/lift_force_checker.sv
module lift_force_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lpd_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [lpd_pkg::DATA_W-1:0]         i_cfg_wdata,
    input  logic                               i_req_valid,
    input  logic                               i_req_ready,
    input  logic [1:0]                         i_opcode,
    input  logic signed [lpd_pkg::DATA_W-1:0]  i_pos_x,
    input  logic signed [lpd_pkg::DATA_W-1:0]  i_pos_y,
    input  logic signed [lpd_pkg::DATA_W-1:0]  i_pos_z,
    input  logic                               i_res_valid,
    input  logic                               i_res_ready,
    input  logic signed [lpd_pkg::DATA_W-1:0]  i_force_x,
    input  logic signed [lpd_pkg::DATA_W-1:0]  i_force_y,
    input  logic signed [lpd_pkg::DATA_W-1:0]  i_force_z,
    input  logic                               i_apply_force,
    input  logic [1:0]                         i_mode,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import lpd_pkg::*;

    typedef logic signed [95:0] wide_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] fx;
        logic signed [DATA_W-1:0] fy;
        logic signed [DATA_W-1:0] fz;
        logic                     apply;
        logic [1:0]               mode;
    } lift_result_t;

    localparam wide_t TOP32 = 96'sd2147483647;
    localparam wide_t BOT32 = -96'sd2147483648;

    // Register shadow
    logic signed [DATA_W-1:0] hmax_q;
    logic signed [DATA_W-1:0] hmin_q;
    logic [GAIN_W-1:0]        up_q;
    logic [GAIN_W-1:0]        down_q;
    logic [GAIN_W-1:0]        inv_q;
    logic [GAIN_W-1:0]        kp_q;
    logic [GAIN_W-1:0]        kd_q;

    // Controller state
    logic [1:0]               mode_q;
    logic signed [DATA_W-1:0] target_q;
    logic signed [DATA_W-1:0] perr_q;
    logic signed [DATA_W-1:0] px_q;
    logic signed [DATA_W-1:0] py_q;
    logic signed [DATA_W-1:0] pz_q;

    lift_result_t expected_forces [$];
    int           mismatches = 0;
    int           pending_n = 0;
    int           results_seen = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = pending_n;

    function automatic wide_t sx(input logic signed [DATA_W-1:0] v);
        return v;
    endfunction

    function automatic wide_t zx(input logic [GAIN_W-1:0] v);
        return $signed({65'd0, v});
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp32(input wide_t v);
        if (v > TOP32) return SAT_MAX;
        if (v < BOT32) return SAT_MIN;
        return v[DATA_W-1:0];
    endfunction

    // Velocity from position delta, then damping against it.
    function automatic logic signed [DATA_W-1:0] lateral_force(
        input logic signed [DATA_W-1:0] now_pos,
        input logic signed [DATA_W-1:0] old_pos
    );
        logic signed [DATA_W-1:0] vel;
        vel = clamp32(((sx(now_pos) - sx(old_pos)) * zx(inv_q)) >>> 16);
        return clamp32((-(sx(vel) * zx(kd_q))) >>> 16);
    endfunction

    function automatic lift_result_t predict_lift_result(
        input logic [1:0]               op,
        input logic signed [DATA_W-1:0] px,
        input logic signed [DATA_W-1:0] py,
        input logic signed [DATA_W-1:0] pz
    );
        lift_result_t             r;
        wide_t                    ramp;
        wide_t                    pd_sum;
        logic signed [DATA_W-1:0] err;
        logic signed [DATA_W-1:0] derr;
        r = '0;
        case (op)
            OP_TICK: begin
                if (mode_q == MODE_RAISING || mode_q == MODE_LOWERING) begin
                    if (mode_q == MODE_RAISING) begin
                        ramp = sx(target_q) + zx(up_q);
                        if (ramp > sx(hmax_q)) ramp = sx(hmax_q);
                    end else begin
                        ramp = sx(target_q) - zx(down_q);
                        // still produce forces on the tick that disables
                        if (ramp < sx(hmin_q)) mode_q = MODE_DISABLED;
                    end
                    target_q = clamp32(ramp);
                    err  = clamp32(sx(target_q) - sx(pz));
                    derr = clamp32(((sx(err) - sx(perr_q)) * zx(inv_q)) >>> 16);
                    perr_q = err;
                    pd_sum = sx(err) * zx(kp_q) + sx(derr) * zx(kd_q);
                    r.fz = clamp32(pd_sum >>> 16);
                    r.fx = lateral_force(px, px_q);
                    r.fy = lateral_force(py, py_q);
                    r.apply = (r.fz > 0);
                end else begin
                    perr_q = '0;
                end
                px_q = px;
                py_q = py;
                pz_q = pz;
            end
            OP_LIFT: begin
                if (mode_q == MODE_LOWERING) begin
                    mode_q = MODE_RAISING;
                end else if (mode_q != MODE_RAISING) begin
                    mode_q   = MODE_RAISING;
                    target_q = pz_q;
                end
            end
            OP_LOWER: begin
                if (mode_q == MODE_RAISING) mode_q = MODE_LOWERING;
            end
            default: begin
                mode_q   = MODE_RAISING;
                target_q = pz;
                px_q     = px;
                py_q     = py;
                pz_q     = pz;
                perr_q   = '0;
            end
        endcase
        r.mode = mode_q;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch: %s", what);
    endtask

    always @(posedge i_clk) begin
        lift_result_t want;
        if (!i_rst_n) begin
            hmax_q   = 32'sd65536;
            hmin_q   = '0;
            up_q     = 31'd65;
            down_q   = 31'd65;
            inv_q    = 31'd65536000;
            kp_q     = '0;
            kd_q     = '0;
            mode_q   = MODE_RAISING;
            target_q = '0;
            perr_q   = '0;
            px_q     = '0;
            py_q     = '0;
            pz_q     = '0;
            expected_forces.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_MAX_HEIGHT: hmax_q = i_cfg_wdata;
                    REG_MIN_HEIGHT: hmin_q = i_cfg_wdata;
                    REG_UP_STEP:    up_q   = i_cfg_wdata[GAIN_W-1:0];
                    REG_DOWN_STEP:  down_q = i_cfg_wdata[GAIN_W-1:0];
                    REG_INV_TICK:   inv_q  = i_cfg_wdata[GAIN_W-1:0];
                    REG_P_GAIN:     kp_q   = i_cfg_wdata[GAIN_W-1:0];
                    REG_D_GAIN:     kd_q   = i_cfg_wdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
            // retire before accepting so a stray result cannot match a new request
            if (i_res_valid && i_res_ready) begin
                results_seen++;
                if (expected_forces.size() == 0) begin
                    report_mismatch($sformatf("result #%0d with no request pending",
                                              results_seen));
                end else begin
                    want = expected_forces.pop_front();
                    if (i_force_x !== want.fx)
                        report_mismatch($sformatf("#%0d force_x %0d, want %0d",
                                                  results_seen, i_force_x, want.fx));
                    if (i_force_y !== want.fy)
                        report_mismatch($sformatf("#%0d force_y %0d, want %0d",
                                                  results_seen, i_force_y, want.fy));
                    if (i_force_z !== want.fz)
                        report_mismatch($sformatf("#%0d force_z %0d, want %0d",
                                                  results_seen, i_force_z, want.fz));
                    if (i_apply_force !== want.apply)
                        report_mismatch($sformatf("#%0d apply_force %b, want %b",
                                                  results_seen, i_apply_force, want.apply));
                    if (i_mode !== want.mode)
                        report_mismatch($sformatf("#%0d mode %0d, want %0d",
                                                  results_seen, i_mode, want.mode));
                end
            end
            if (i_req_valid && i_req_ready)
                expected_forces.push_back(
                    predict_lift_result(i_opcode, i_pos_x, i_pos_y, i_pos_z));
        end
        pending_n <= expected_forces.size();
    end

endmodule

>>> bench/tb_lift_pd_controller_with_ramp.sv
module tb_lift_pd_controller_with_ramp;
    import lpd_pkg::*;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 230;
    localparam int SETTLE_CYCLES   = 16;
    localparam int CYCLE_LIMIT     = 400000;

    localparam int CFG_TYPICAL  = 0;
    localparam int CFG_ALL_HIGH = 1;
    localparam int CFG_ALL_LOW  = 2;
    localparam int CFG_WILD     = 3;

    localparam int PHASE_STYLE [PHASES] = '{CFG_TYPICAL, CFG_ALL_HIGH, CFG_TYPICAL, CFG_WILD,
                                            CFG_ALL_LOW, CFG_TYPICAL, CFG_WILD, CFG_TYPICAL};

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]    cfg_addr = '0;
    logic [DATA_W-1:0]        cfg_wdata = '0;
    logic                     req_valid = 1'b0;
    logic                     req_ready;
    logic [1:0]               req_op = OP_TICK;
    logic signed [DATA_W-1:0] req_x = '0;
    logic signed [DATA_W-1:0] req_y = '0;
    logic signed [DATA_W-1:0] req_z = '0;
    logic                     res_valid;
    logic                     res_ready = 1'b0;
    logic signed [DATA_W-1:0] res_fx;
    logic signed [DATA_W-1:0] res_fy;
    logic signed [DATA_W-1:0] res_fz;
    logic                     res_apply;
    logic [1:0]               res_mode;

    int mismatches;
    int pending;
    int idle_pct = 0;
    int stall_pct = 0;
    int cycles = 0;

    logic [DATA_W-1:0]        cfg_max, cfg_min, cfg_up, cfg_down, cfg_inv, cfg_kp, cfg_kd;
    logic signed [DATA_W-1:0] cur_x = '0;
    logic signed [DATA_W-1:0] cur_y = '0;
    logic signed [DATA_W-1:0] cur_z = '0;

    lift_pd_controller_with_ramp dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wdata   (cfg_wdata),
        .i_valid       (req_valid),
        .o_ready       (req_ready),
        .i_opcode      (req_op),
        .i_pos_x       (req_x),
        .i_pos_y       (req_y),
        .i_pos_z       (req_z),
        .o_valid       (res_valid),
        .i_ready       (res_ready),
        .o_force_x     (res_fx),
        .o_force_y     (res_fy),
        .o_force_z     (res_fz),
        .o_apply_force (res_apply),
        .o_mode        (res_mode)
    );

    lift_force_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wdata   (cfg_wdata),
        .i_req_valid   (req_valid),
        .i_req_ready   (req_ready),
        .i_opcode      (req_op),
        .i_pos_x       (req_x),
        .i_pos_y       (req_y),
        .i_pos_z       (req_z),
        .i_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .i_force_x     (res_fx),
        .i_force_y     (res_fy),
        .i_force_z     (res_fz),
        .i_apply_force (res_apply),
        .i_mode        (res_mode),
        .o_fail_count  (mismatches),
        .o_pending     (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) res_ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_req(input logic [1:0] op, input logic signed [DATA_W-1:0] x,
                            input logic signed [DATA_W-1:0] y,
                            input logic signed [DATA_W-1:0] z);
        while ($urandom_range(0, 99) < idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_op    <= op;
        req_x     <= x;
        req_y     <= y;
        req_z     <= z;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    // Hold requests until every result is back, then let the block settle.
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic program_config(input int style);
        case (style)
            CFG_ALL_HIGH: begin
                cfg_max = SAT_MAX;
                cfg_min = SAT_MIN;
                cfg_up = '1; cfg_down = '1; cfg_inv = '1; cfg_kp = '1; cfg_kd = '1;
            end
            CFG_ALL_LOW: begin
                cfg_max = SAT_MIN;
                cfg_min = SAT_MAX;
                cfg_up = '0; cfg_down = '0; cfg_inv = '0; cfg_kp = '0; cfg_kd = '0;
            end
            CFG_WILD: begin
                cfg_max = $urandom; cfg_min = $urandom; cfg_up = $urandom;
                cfg_down = $urandom; cfg_inv = $urandom; cfg_kp = $urandom;
                cfg_kd = $urandom;
            end
            default: begin
                cfg_max  = $urandom_range(32'h0001_0000, 32'h0004_0000);
                cfg_min  = $urandom_range(0, 32'h0000_8000);
                cfg_up   = $urandom_range(32'h0000_0100, 32'h0000_2000);
                cfg_down = $urandom_range(32'h0000_0800, 32'h0000_8000);
                cfg_inv  = $urandom_range(32'h000A_0000, 32'h07D0_0000);
                cfg_kp   = $urandom_range(0, 32'h0004_0000);
                cfg_kd   = $urandom_range(0, 32'h0000_4000);
            end
        endcase
        write_reg(REG_MAX_HEIGHT, cfg_max);
        write_reg(REG_MIN_HEIGHT, cfg_min);
        write_reg(REG_UP_STEP, cfg_up);
        write_reg(REG_DOWN_STEP, cfg_down);
        write_reg(REG_INV_TICK, cfg_inv);
        write_reg(REG_P_GAIN, cfg_kp);
        write_reg(REG_D_GAIN, cfg_kd);
        cfg_we <= 1'b0;
    endtask

    function automatic int drift();
        return $urandom_range(0, 2048) - 1024;
    endfunction

    initial begin
        int         phase;
        int         n;
        int         roll;
        logic [1:0] op;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values: ramp, lower to disable, idle tick, re-lift, start at extremes.
        send_req(OP_TICK, '0, '0, '0);
        send_req(OP_LOWER, '0, '0, '0);
        send_req(OP_TICK, 32'sd100, -32'sd100, 32'sd7);
        send_req(OP_TICK, '0, '0, '0);
        send_req(OP_TICK, SAT_MAX, SAT_MIN, 32'sh0001_0000);
        send_req(OP_LOWER, '0, '0, '0);
        send_req(OP_LIFT, '0, '0, '0);
        send_req(OP_LIFT, '0, '0, '0);
        send_req(OP_START, SAT_MAX, SAT_MIN, SAT_MAX);
        drain();

        // Saturate everything: full gains, full steps, widest height range.
        program_config(CFG_ALL_HIGH);
        send_req(OP_TICK, SAT_MIN, SAT_MAX, SAT_MIN);
        send_req(OP_TICK, '0, '0, '0);
        send_req(OP_TICK, -32'sd1, 32'sd1, SAT_MAX);
        send_req(OP_LOWER, '0, '0, '0);
        send_req(OP_TICK, SAT_MAX, SAT_MIN, '0);
        send_req(OP_TICK, SAT_MIN, SAT_MIN, SAT_MIN);
        send_req(OP_LIFT, '0, '0, '0);
        send_req(OP_LOWER, '0, '0, '0);
        send_req(OP_LIFT, '0, '0, '0);
        send_req(OP_START, SAT_MIN, SAT_MIN, SAT_MIN);
        send_req(OP_TICK, SAT_MAX, SAT_MAX, SAT_MAX);
        send_req(OP_TICK, SAT_MIN, SAT_MAX, -32'sd1);
        drain();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 59; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 59; end
                default: begin idle_pct = 29; stall_pct <= 29; end
            endcase
            program_config(PHASE_STYLE[phase]);
            cur_z = $urandom_range(0, 32'h0004_0000);
            send_req(OP_START, cur_x, cur_y, cur_z);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 70)      op = OP_TICK;
                else if (roll < 82) op = OP_LOWER;
                else if (roll < 91) op = OP_LIFT;
                else                op = OP_START;
                if (op == OP_START) cur_z = $urandom_range(0, 32'h0004_0000);
                cur_x = cur_x + drift();
                cur_y = cur_y + drift();
                cur_z = cur_z + drift();
                if ($urandom_range(0, 99) < 8)
                    send_req(op, $urandom, $urandom, $urandom);
                else
                    send_req(op, cur_x, cur_y, cur_z);
                if (n % 97 == 48) drain();
            end
            drain();
        end

        if (mismatches == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule
